// File: rtl/mmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared types and constants of the multichannel min/max decimator.
// ----------------------------------------------------------------------------
package mmd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CHAN_OUT_W = 6;
    localparam int COUNT_W    = 40;
    localparam int FIB_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 40;
    localparam int CH_CNT_W   = 7;
    localparam int BLK_CFG_W  = 17;
    localparam int OUT_DATA_W = 80;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_FRAMES  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RECORD_FRAMES = 2'd2;

    // largest legal block length, as is and minus one; reset values minus one
    localparam logic [BLK_CFG_W-1:0] BLOCK_FRAMES_MAX = 17'd65536;
    localparam logic [FIB_W-1:0]     BLOCK_LAST_MAX   = 16'hFFFF;
    localparam logic [FIB_W-1:0]     BLOCK_LAST_RST   = 16'd63;
    localparam logic [COUNT_W-1:0]   RECORD_LAST_RST  = 40'd0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
        logic                       emit;
        logic                       last_ch;
        logic                       last_rec;
        logic [COUNT_W-1:0]         block_number;
    } mmd_item_t;

    typedef struct packed {
        logic [CHAN_OUT_W-1:0]      channel_index;
        logic signed [SAMPLE_W-1:0] block_min;
        logic signed [SAMPLE_W-1:0] block_max;
        logic [COUNT_W-1:0]         block_index;
        logic                       last_channel;
        logic                       last_block;
    } mmd_result_t;

endpackage
`default_nettype wire

// File: rtl/mmd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_ctrl
// Configuration registers and channel / frame / block position counters.
// ----------------------------------------------------------------------------
module mmd_ctrl
    import mmd_pkg::*;
#(
    parameter int MAX_CHANNELS = 64,
    parameter int CW           = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  accept,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic      [CW-1:0]         ch,
    output mmd_item_t                  item
);

    localparam int CNT_CMP_W = 9;
    localparam logic [CNT_CMP_W-1:0] MAX_CH_CMP = CNT_CMP_W'(MAX_CHANNELS);
    localparam logic [CW-1:0]        CH_LAST_MAX = CW'(MAX_CHANNELS - 1);

    logic [CW-1:0]      cc_last_reg, cc_last_next;
    logic [FIB_W-1:0]   blk_last_reg, blk_last_next;
    logic [COUNT_W-1:0] rec_last_reg, rec_last_next;

    logic [CW-1:0]      pos_reg, pos_next;
    logic [FIB_W-1:0]   fib_reg, fib_next;
    logic [COUNT_W-1:0] fd_reg, fd_next;
    logic [COUNT_W-1:0] bn_reg, bn_next;

    logic [CNT_CMP_W-1:0] cnt_ext;
    logic [BLK_CFG_W-1:0] blk_val;
    logic [COUNT_W-1:0]   rec_val;
    logic                 last_ch, end_block, end_rec;

    // config is stored as effective length minus one
    always_comb
    begin
        cnt_ext       = {2'b00, cfg_wdata[CH_CNT_W-1:0]};
        blk_val       = cfg_wdata[BLK_CFG_W-1:0];
        rec_val       = cfg_wdata[COUNT_W-1:0];
        cc_last_next  = cc_last_reg;
        blk_last_next = blk_last_reg;
        rec_last_next = rec_last_reg;
        if (cfg_wen)
        begin
            unique case (cfg_addr)
                CFG_CHANNEL_COUNT:
                begin
                    if (cnt_ext == '0)
                        cc_last_next = '0;
                    else if (cnt_ext >= MAX_CH_CMP)
                        cc_last_next = CH_LAST_MAX;
                    else
                        cc_last_next = CW'(cnt_ext - CNT_CMP_W'(1));
                end
                CFG_BLOCK_FRAMES:
                begin
                    if (blk_val == '0)
                        blk_last_next = '0;
                    else if (blk_val > BLOCK_FRAMES_MAX)
                        blk_last_next = BLOCK_LAST_MAX;
                    else
                        blk_last_next = FIB_W'(blk_val - BLK_CFG_W'(1));
                end
                CFG_RECORD_FRAMES:
                begin
                    if (rec_val == '0)
                        rec_last_next = '0;
                    else
                        rec_last_next = rec_val - COUNT_W'(1);
                end
                default:
                begin
                    cc_last_next = cc_last_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        ch        = (pos_reg > cc_last_reg) ? cc_last_reg : pos_reg;
        last_ch   = (ch == cc_last_reg);
        end_block = (fib_reg >= blk_last_reg);
        end_rec   = (fd_reg >= rec_last_reg);

        item.sample       = sample;
        item.first        = (fib_reg == '0);
        item.emit         = end_block || end_rec;
        item.last_ch      = last_ch;
        item.last_rec     = end_rec;
        item.block_number = bn_reg;

        pos_next = pos_reg;
        fib_next = fib_reg;
        fd_next  = fd_reg;
        bn_next  = bn_reg;
        if (accept)
        begin
            if (last_ch)
            begin
                pos_next = '0;
                if (end_rec)
                begin
                    fib_next = '0;
                    fd_next  = '0;
                    bn_next  = '0;
                end
                else
                begin
                    fd_next = fd_reg + COUNT_W'(1);
                    if (end_block)
                    begin
                        fib_next = '0;
                        bn_next  = bn_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        fib_next = fib_reg + FIB_W'(1);
                    end
                end
            end
            else
            begin
                pos_next = ch + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_last_reg  <= '0;
            blk_last_reg <= BLOCK_LAST_RST;
            rec_last_reg <= RECORD_LAST_RST;
            pos_reg      <= '0;
            fib_reg      <= '0;
            fd_reg       <= '0;
            bn_reg       <= '0;
        end
        else
        begin
            cc_last_reg  <= cc_last_next;
            blk_last_reg <= blk_last_next;
            rec_last_reg <= rec_last_next;
            pos_reg      <= pos_next;
            fib_reg      <= fib_next;
            fd_reg       <= fd_next;
            bn_reg       <= bn_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mmd_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_store
// Per-channel min/max memory with read-modify-write stage and forwarding.
// ----------------------------------------------------------------------------
module mmd_store
    import mmd_pkg::*;
#(
    parameter int MAX_CHANNELS = 64,
    parameter int CW           = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [CW-1:0] ch,
    input  wire mmd_item_t   item,
    input  wire logic        out_free,
    output logic             in_ready,
    output logic             res_valid,
    output mmd_result_t      res
);

    logic signed [SAMPLE_W-1:0] min_mem [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] max_mem [MAX_CHANNELS];

    logic signed [SAMPLE_W-1:0] rd_min_reg, rd_max_reg;
    logic signed [SAMPLE_W-1:0] fwd_min_reg, fwd_max_reg;
    logic                       fwd_hit_reg, fwd_hit_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic [CW-1:0]              s1_ch_reg;
    mmd_item_t                  s1_item_reg;

    logic signed [SAMPLE_W-1:0] cur_min, cur_max, smp, new_min, new_max;
    logic                       advance;

    always_comb
    begin
        smp     = s1_item_reg.sample;
        cur_min = fwd_hit_reg ? fwd_min_reg : rd_min_reg;
        cur_max = fwd_hit_reg ? fwd_max_reg : rd_max_reg;
        if (s1_item_reg.first)
        begin
            new_min = smp;
            new_max = smp;
        end
        else
        begin
            new_min = (smp < cur_min) ? smp : cur_min;
            new_max = (smp > cur_max) ? smp : cur_max;
        end

        advance       = s1_valid_reg && (!s1_item_reg.emit || out_free);
        in_ready      = !s1_valid_reg || advance;
        res_valid     = advance && s1_item_reg.emit;
        fwd_hit_next  = advance && (s1_ch_reg == ch);
        s1_valid_next = accept || (s1_valid_reg && !advance);

        res.channel_index = CHAN_OUT_W'(s1_ch_reg);
        res.block_min     = new_min;
        res.block_max     = new_max;
        res.block_index   = s1_item_reg.block_number;
        res.last_channel  = s1_item_reg.last_ch;
        res.last_block    = s1_item_reg.last_rec;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            min_mem[s1_ch_reg] <= new_min;
            max_mem[s1_ch_reg] <= new_max;
        end
        if (accept)
        begin
            rd_min_reg  <= min_mem[ch];
            rd_max_reg  <= max_mem[ch];
            fwd_min_reg <= new_min;
            fwd_max_reg <= new_max;
            fwd_hit_reg <= fwd_hit_next;
            s1_ch_reg   <= ch;
            s1_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

endmodule
`default_nettype wire

// File: rtl/multichannel_min_max_decimator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_min_max_decimator
// Per-channel min/max over blocks of frames of interleaved 16-bit samples.
// ----------------------------------------------------------------------------
// Path: a sample is registered in the store stage, its result word in the output register.
// Throughput: one sample word per cycle; the input stalls only while a finished
// result waits behind a held output word. The min/max memory does one read and
// one write per cycle, writes forwarded to a read of the same channel.
// Reset: 1 channel, 64-frame blocks, 1-frame record, counters zero; the
// min/max memory is not cleared.
// ----------------------------------------------------------------------------
module multichannel_min_max_decimator
    import mmd_pkg::*;
#(
    parameter int MAX_CHANNELS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,  // sample
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // channel_index, block_min, block_max, block_index, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,  // last_block
    output logic                       m_axis_tuser   // last_channel
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic           accept, in_ready, res_valid, out_free;
    logic [CW-1:0]  ch;
    mmd_item_t      item;
    mmd_result_t    res;
    mmd_result_t    out_reg;
    logic           out_valid_reg, out_valid_next;

    assign accept        = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    mmd_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CW           (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .sample    (s_axis_tdata),
        .ch        (ch),
        .item      (item)
    );

    mmd_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CW           (CW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (ch),
        .item      (item),
        .out_free  (out_free),
        .in_ready  (in_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = res_valid || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.block_index, out_reg.block_max,
                            out_reg.block_min, out_reg.channel_index};
    assign m_axis_tlast  = out_reg.last_block;
    assign m_axis_tuser  = out_reg.last_channel;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && out_valid_reg && !m_axis_tready))
        else $error("result loaded over a held output word");

    a_rise_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(res_valid))
        else $error("output valid without a finished result");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_free) |-> !s_axis_tready)
        else $error("input taken while result stage is stalled");

endmodule
`default_nettype wire

// File: tb/sv/multichannel_min_max_decimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_min_max_decimator_test
// Streams interleaved samples through the decimator under several channel,
// block and record settings. A scoreboard class keeps its own copy of the
// per-channel min/max state and compares every result word field by field.
// Both stream sides idle at random, and the output is held off once for a
// long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module multichannel_min_max_decimator_test;

    import mmd_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    class min_max_scoreboard;
        localparam int NCH = 64;

        logic [CH_CNT_W-1:0]        chan_count_reg;
        logic [BLK_CFG_W-1:0]       block_len_reg;
        logic [COUNT_W-1:0]         record_len_reg;
        logic signed [SAMPLE_W-1:0] lo_store [NCH];
        logic signed [SAMPLE_W-1:0] hi_store [NCH];
        bit                         written [NCH];
        int unsigned                chan_pos;
        int unsigned                frame_pos;
        logic [COUNT_W-1:0]         frame_count;
        logic [COUNT_W-1:0]         block_seq;
        mmd_result_t                pending [$];
        int                         mismatches;
        int                         samples_seen;
        int                         words_seen;

        function new();
            chan_count_reg = 7'd1;
            block_len_reg  = 17'd64;
            record_len_reg = 40'd1;
            chan_pos       = 0;
            frame_pos      = 0;
            frame_count    = '0;
            block_seq      = '0;
            mismatches     = 0;
            samples_seen   = 0;
            words_seen     = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int unsigned channels_of(logic [CH_CNT_W-1:0] v);
            int unsigned c;
            c = v;
            if (c == 0) c = 1;
            if (c > NCH) c = NCH;
            return c;
        endfunction

        function int unsigned block_of(logic [BLK_CFG_W-1:0] v);
            int unsigned b;
            b = v;
            if (b == 0) b = 1;
            if (b > 65536) b = 65536;
            return b;
        endfunction

        function void note_reg(logic [CFG_ADDR_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_CHANNEL_COUNT: chan_count_reg = value[CH_CNT_W-1:0];
                CFG_BLOCK_FRAMES:  block_len_reg  = value[BLK_CFG_W-1:0];
                CFG_RECORD_FRAMES: record_len_reg = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // mid-block, every channel below the new count must already hold a value
        function bit channel_count_safe(logic [CFG_DATA_W-1:0] value);
            int unsigned c;
            c = channels_of(value[CH_CNT_W-1:0]);
            if (frame_pos == 0) return 1'b1;
            for (int i = 0; i < c; i++)
                if (!written[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw);
            int unsigned                cc;
            int unsigned                bf;
            int unsigned                ch;
            logic [COUNT_W-1:0]         rf;
            logic signed [SAMPLE_W-1:0] v;
            bit                         last_ch;
            bit                         end_blk;
            bit                         end_rec;
            mmd_result_t                r;
            cc = channels_of(chan_count_reg);
            bf = block_of(block_len_reg);
            rf = (record_len_reg == '0) ? 40'd1 : record_len_reg;
            v  = raw;
            ch = (chan_pos < cc) ? chan_pos : cc - 1;
            last_ch = (ch == cc - 1);
            samples_seen++;

            if (frame_pos == 0) begin
                lo_store[ch] = v;
                hi_store[ch] = v;
                written[ch]  = 1'b1;
            end
            else begin
                if (v < lo_store[ch]) lo_store[ch] = v;
                if (v > hi_store[ch]) hi_store[ch] = v;
            end

            end_blk = (frame_pos + 1 >= bf);
            end_rec = ({1'b0, frame_count} + 41'd1 >= {1'b0, rf});

            if (end_blk || end_rec) begin
                r.channel_index = ch[CHAN_OUT_W-1:0];
                r.block_min     = lo_store[ch];
                r.block_max     = hi_store[ch];
                r.block_index   = block_seq;
                r.last_channel  = last_ch;
                r.last_block    = end_rec;
                pending.insert(pending.size(), r);
            end

            if (last_ch) begin
                chan_pos = 0;
                if (end_rec) begin
                    frame_pos   = 0;
                    frame_count = '0;
                    block_seq   = '0;
                end
                else begin
                    frame_count = frame_count + 1'b1;
                    if (end_blk) begin
                        frame_pos = 0;
                        block_seq = block_seq + 1'b1;
                    end
                    else begin
                        frame_pos++;
                    end
                end
            end
            else begin
                chan_pos = ch + 1;
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch %0d: %s", mismatches, msg);
        endtask

        task compare_field(string name, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
            if (got !== want)
                report($sformatf("word %0d %s got %h want %h", words_seen, name, got, want));
        endtask

        task check_word(logic [OUT_DATA_W-1:0] data, logic tlast, logic tuser);
            mmd_result_t want;
            words_seen++;
            if (pending.size() == 0) begin
                report($sformatf("word %0d arrived with nothing expected", words_seen));
                return;
            end
            want = pending.pop_front();
            compare_field("channel_index", data[5:0], want.channel_index);
            compare_field("block_min", data[21:6], $unsigned(want.block_min));
            compare_field("block_max", data[37:22], $unsigned(want.block_max));
            compare_field("block_index", data[77:38], want.block_index);
            compare_field("pad", data[79:78], 2'b00);
            compare_field("last_channel", tuser, want.last_channel);
            compare_field("last_block", tlast, want.last_block);
        endtask
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wen       = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    min_max_scoreboard sb = new();

    int tx_idle_pct   = 8;
    int rx_idle_pct   = 55;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int settings_used = 0;

    multichannel_min_max_decimator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // output back-pressure; a long hold-off is counted here
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    task automatic send_word(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge clk);
        sb.note_reg(index, value);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] chans,
                             input logic [CFG_DATA_W-1:0] blk,
                             input logic [CFG_DATA_W-1:0] rec);
        if (sb.channel_count_safe(chans)) write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_BLOCK_FRAMES, blk);
        write_reg(CFG_RECORD_FRAMES, rec);
        cfg_wen <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return SAMPLE_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_phase();
        logic [CFG_DATA_W-1:0] chans;
        logic [CFG_DATA_W-1:0] blk;
        logic [CFG_DATA_W-1:0] rec;
        int                    count;
        case ($urandom_range(9))
            0:       chans = 0;
            1:       chans = 64;
            2:       chans = $urandom_range(127, 65);
            default: chans = $urandom_range(6, 1);
        endcase
        case ($urandom_range(7))
            0:       blk = 0;
            1:       blk = 1;
            2:       blk = 65536;
            3:       blk = $urandom_range(131071, 65537);
            default: blk = $urandom_range(5, 2);
        endcase
        case ($urandom_range(7))
            0:       rec = 0;
            1:       rec = 40'hFF_FFFF_FFFF;
            2:       rec = 1;
            default: rec = $urandom_range(24, 1);
        endcase
        if (blk >= 65536 && rec > 8) rec = $urandom_range(8, 1);
        configure(chans, blk, rec);
        if (sb.channels_of(sb.chan_count_reg) == 64)
            count = 64 * $urandom_range(2, 1);
        else
            count = $urandom_range(40, 10);
        repeat (count) send_word(pick_word());
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one channel, each word closes a one-frame record
        send_word(16'h8000);
        send_word(16'h7FFF);
        send_word(16'h0000);
        send_word(16'hFFFF);
        drain();

        // full two-frame block, then a partial one closing the record
        configure(2, 2, 3);
        send_word(16'h7FFF);
        send_word(16'h8000);
        send_word(16'h8000);
        send_word(16'h7FFF);
        send_word(16'h0001);
        send_word(16'hFFFE);
        drain();

        // zero registers act as one
        configure(0, 0, 0);
        send_word(16'h1234);
        send_word(16'hEDCB);
        drain();

        // oversized block, closed by the record
        configure(1, 131071, 3);
        repeat (3) send_word(pick_word());
        drain();

        // shrink all three mid-block: clamps to last channel, frame and record
        configure(3, 4, 10);
        repeat (5) send_word(pick_word());
        drain();
        configure(2, 2, 1);
        repeat (2) send_word(pick_word());
        drain();

        tx_idle_pct = 8;
        rx_idle_pct = 55;
        while (sb.samples_seen < 170) random_phase();

        tx_idle_pct = 55;
        rx_idle_pct = 8;
        while (sb.samples_seen < 310) random_phase();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(3, 1, 40'hFF_FFFF_FFFF);
        hold_request = 1'b1;
        repeat (60) send_word(pick_word());
        drain();
        while (sb.samples_seen < 400) random_phase();

        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected words never arrived", sb.pending.size()));

        $display("run covered %0d samples and %0d result words over %0d register settings",
                 sb.samples_seen, sb.words_seen, settings_used);
        $display("mismatches counted: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/mmd_pkg.sv
rtl/mmd_ctrl.sv
rtl/mmd_store.sv
rtl/multichannel_min_max_decimator.sv
tb/sv/multichannel_min_max_decimator_test.sv
